### sv/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg: epoch to calendar shared definitions
// Widths, calendar constants, reciprocal constants for the divisions, month
// length and leap year helpers, and the result type of the shared
// compare/subtract unit.
// ----------------------------------------------------------------------------
package e2c_pkg;

   localparam int EPOCH_W  = 31;
   localparam int OFFSET_W = 11;
   localparam int LOCAL_W  = 32;
   localparam int UNIT_W   = 18;
   localparam int DAYS_W   = 15;

   // shared multiplier: quotient by reciprocal, then quotient times divisor
   localparam int MUL_A_W  = 25;
   localparam int MUL_B_W  = 26;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int DAY_PRE  = LOCAL_W - MUL_A_W;   // 86400 = 128 * 675

   localparam logic [MUL_B_W-1:0] DAY_RECIP  = MUL_B_W'(50903317);  // 2^35 / 675
   localparam logic [MUL_B_W-1:0] HOUR_RECIP = MUL_B_W'(9321);      // 2^21 / 225
   localparam logic [MUL_B_W-1:0] MIN_RECIP  = MUL_B_W'(1093);      // 2^14 / 15
   localparam logic [MUL_B_W-1:0] WDAY_RECIP = MUL_B_W'(37450);     // 2^18 / 7
   localparam int DAY_SHIFT  = 35;
   localparam int HOUR_SHIFT = 21;
   localparam int MIN_SHIFT  = 14;
   localparam int WDAY_SHIFT = 18;

   localparam logic [UNIT_W-1:0] SEC_PER_DAY   = UNIT_W'(86400);
   localparam logic [UNIT_W-1:0] SEC_PER_HOUR  = UNIT_W'(3600);
   localparam logic [UNIT_W-1:0] SEC_PER_MIN   = UNIT_W'(60);
   localparam logic [UNIT_W-1:0] DAYS_PER_WEEK = UNIT_W'(7);
   localparam logic [UNIT_W-1:0] DAYS_LEAP     = UNIT_W'(366);
   localparam logic [UNIT_W-1:0] DAYS_COMMON   = UNIT_W'(365);

   localparam logic [7:0] BASE_YEAR_OFS = 8'd70;   // 1970 - 1900
   localparam logic [3:0] LAST_MONTH    = 4'd11;
   localparam logic [3:0] FEBRUARY      = 4'd1;
   localparam logic [15:0] EPOCH_WDAY   = 16'd4;   // Thursday

   typedef struct packed {
      logic              ge;
      logic [UNIT_W-1:0] diff;
   } csub_type;

   // year is years since 1900; centuries in range are 1900, 2000, 2100
   function automatic logic is_leap(input logic [7:0] year);
      is_leap = (year[1:0] == 2'b00) && (year != 8'd0) && (year != 8'd200);
   endfunction

   function automatic logic [UNIT_W-1:0] month_days(input logic [3:0] mon,
                                                    input logic       leap);
      logic [4:0] d;
      unique case (mon)
         4'd0:    d = 5'd31;
         4'd1:    d = leap ? 5'd29 : 5'd28;
         4'd2:    d = 5'd31;
         4'd3:    d = 5'd30;
         4'd4:    d = 5'd31;
         4'd5:    d = 5'd30;
         4'd6:    d = 5'd31;
         4'd7:    d = 5'd31;
         4'd8:    d = 5'd30;
         4'd9:    d = 5'd31;
         4'd10:   d = 5'd30;
         default: d = 5'd31;
      endcase
      month_days = UNIT_W'(d);
   endfunction

endpackage

### sv/e2c_csub.sv
// ----------------------------------------------------------------------------
// e2c_csub: shared compare/subtract unit
// One subtractor gives both a - b and the a >= b flag from its borrow.
// ----------------------------------------------------------------------------
module e2c_csub (
   input  logic [e2c_pkg::UNIT_W-1:0] a,
   input  logic [e2c_pkg::UNIT_W-1:0] b,
   output e2c_pkg::csub_type          res
);
   import e2c_pkg::*;

   logic [UNIT_W:0] full;

   assign full     = {1'b0, a} - {1'b0, b};
   assign res.ge   = ~full[UNIT_W];
   assign res.diff = full[UNIT_W-1:0];

endmodule

### sv/epoch_to_calendar_with_offset_unit.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar_with_offset_unit: Unix epoch to local calendar fields
// Adds the time-zone offset, clamps negative local time to zero and splits
// it into second, minute, hour, weekday, day of month, month and year.
//
// Usage:
//   Pulse start with req_epoch_seconds while busy is low; the item is taken
//   on that edge and busy rises. When the result is ready, rsp_valid is high
//   for exactly one cycle with all rsp_ fields; busy is low in that cycle so
//   the next item may start at once. The receiver has no stall.
//   csr_wr_en / csr_wr_data write the signed offset in minutes; write only
//   while busy is low. Reset clears the offset to 0, returns to idle and
//   holds busy high while asserted.
// Sequence:
//   Divisions by 86400, 3600, 60 and 7 each take a quotient step on one
//   shared 25x26 multiplier (reciprocal) and a remainder step on the shared
//   18-bit compare/subtract unit. Then one compare per year from 1970 to the
//   local year and one per month up to the local month. One item is in
//   flight at a time.
// ----------------------------------------------------------------------------
module epoch_to_calendar_with_offset_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [e2c_pkg::EPOCH_W-1:0]            req_epoch_seconds,
   input  logic                                   csr_wr_en,
   input  logic signed [e2c_pkg::OFFSET_W-1:0]    csr_wr_data,
   output logic                                   rsp_valid,
   output logic [5:0]                             rsp_second,
   output logic [5:0]                             rsp_minute,
   output logic [4:0]                             rsp_hour,
   output logic [4:0]                             rsp_day_of_month,
   output logic [3:0]                             rsp_month_index,
   output logic [7:0]                             rsp_years_since_1900,
   output logic [2:0]                             rsp_weekday
);
   import e2c_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DAY_Q, S_DAY_R, S_HOUR_Q, S_HOUR_R, S_MIN_Q, S_MIN_R,
      S_WDAY_Q, S_WDAY_R, S_YEAR, S_MONTH
   } state_type;

   state_type                   state_ff;
   logic signed [OFFSET_W-1:0]  tz_offset_ff;
   logic [LOCAL_W-1:0]          num_ff;
   logic [DAYS_W-1:0]           quot_ff;
   logic [DAYS_W-1:0]           days_ff;
   logic [7:0]                  year_ff;
   logic [3:0]                  mon_ff;
   logic [4:0]                  hour_ff;
   logic [5:0]                  min_ff;
   logic [5:0]                  sec_ff;
   logic [2:0]                  wday_ff;
   logic                        rsp_valid_ff;

   logic signed [LOCAL_W:0]     local_sum;
   logic [LOCAL_W-1:0]          local_in;
   logic [MUL_A_W-1:0]          mul_a;
   logic [MUL_B_W-1:0]          mul_b;
   logic [PROD_W-1:0]           prod;
   logic [DAYS_W-1:0]           quot_in;
   logic [UNIT_W-1:0]           unit_a;
   logic [UNIT_W-1:0]           unit_b;
   csub_type                    unit_res;
   logic [15:0]                 wday_num;
   logic                        leap;

   assign local_sum = $signed({2'b00, req_epoch_seconds})
                    + (LOCAL_W+1)'(tz_offset_ff) * $signed((LOCAL_W+1)'(60));
   assign local_in  = local_sum[LOCAL_W] ? '0 : local_sum[LOCAL_W-1:0];
   assign leap      = is_leap(year_ff);

   // quotient cycles multiply by a reciprocal, remainder cycles multiply the
   // quotient back and subtract it from the low bits of the dividend
   always_comb begin
      mul_a   = MUL_A_W'(quot_ff);
      mul_b   = '0;
      quot_in = '0;
      unit_a  = num_ff[UNIT_W-1:0];
      unit_b  = prod[UNIT_W-1:0];
      unique case (state_ff)
         S_DAY_Q: begin
            mul_a   = num_ff[LOCAL_W-1:DAY_PRE];
            mul_b   = DAY_RECIP;
            quot_in = prod[DAY_SHIFT +: DAYS_W];
         end
         S_HOUR_Q: begin
            mul_a   = MUL_A_W'(num_ff[16:4]);   // 3600 = 16 * 225
            mul_b   = HOUR_RECIP;
            quot_in = DAYS_W'(prod[HOUR_SHIFT +: 5]);
         end
         S_MIN_Q: begin
            mul_a   = MUL_A_W'(num_ff[11:2]);   // 60 = 4 * 15
            mul_b   = MIN_RECIP;
            quot_in = DAYS_W'(prod[MIN_SHIFT +: 6]);
         end
         S_WDAY_Q: begin
            mul_a   = MUL_A_W'(num_ff[DAYS_W-1:0]);
            mul_b   = WDAY_RECIP;
            quot_in = DAYS_W'(prod[WDAY_SHIFT +: 12]);
         end
         S_DAY_R:  mul_b = MUL_B_W'(SEC_PER_DAY);
         S_HOUR_R: mul_b = MUL_B_W'(SEC_PER_HOUR);
         S_MIN_R:  mul_b = MUL_B_W'(SEC_PER_MIN);
         S_WDAY_R: mul_b = MUL_B_W'(DAYS_PER_WEEK);
         S_YEAR: begin
            unit_a = UNIT_W'(days_ff);
            unit_b = leap ? DAYS_LEAP : DAYS_COMMON;
         end
         S_MONTH: begin
            unit_a = UNIT_W'(days_ff);
            unit_b = month_days(mon_ff, leap);
         end
         default: ;
      endcase
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   e2c_csub u_csub (
      .a   (unit_a),
      .b   (unit_b),
      .res (unit_res)
   );

   assign wday_num = 16'(days_ff) + EPOCH_WDAY;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_offset_ff <= '0;
      end else if (csr_wr_en) begin
         tz_offset_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  num_ff   <= local_in;
                  state_ff <= S_DAY_Q;
               end
            end
            S_DAY_Q: begin
               quot_ff  <= quot_in;
               days_ff  <= quot_in;
               state_ff <= S_DAY_R;
            end
            S_DAY_R: begin
               num_ff   <= LOCAL_W'(unit_res.diff);
               state_ff <= S_HOUR_Q;
            end
            S_HOUR_Q: begin
               quot_ff  <= quot_in;
               hour_ff  <= quot_in[4:0];
               state_ff <= S_HOUR_R;
            end
            S_HOUR_R: begin
               num_ff   <= LOCAL_W'(unit_res.diff);
               state_ff <= S_MIN_Q;
            end
            S_MIN_Q: begin
               quot_ff  <= quot_in;
               min_ff   <= quot_in[5:0];
               state_ff <= S_MIN_R;
            end
            S_MIN_R: begin
               sec_ff   <= unit_res.diff[5:0];
               num_ff   <= LOCAL_W'(wday_num);
               state_ff <= S_WDAY_Q;
            end
            S_WDAY_Q: begin
               quot_ff  <= quot_in;
               state_ff <= S_WDAY_R;
            end
            S_WDAY_R: begin
               wday_ff  <= unit_res.diff[2:0];
               year_ff  <= BASE_YEAR_OFS;
               state_ff <= S_YEAR;
            end
            S_YEAR: begin
               if (unit_res.ge) begin
                  days_ff <= unit_res.diff[DAYS_W-1:0];
                  year_ff <= year_ff + 8'd1;
               end else begin
                  mon_ff   <= '0;
                  state_ff <= S_MONTH;
               end
            end
            default: begin
               if (mon_ff != LAST_MONTH && unit_res.ge) begin
                  days_ff <= unit_res.diff[DAYS_W-1:0];
                  mon_ff  <= mon_ff + 4'd1;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign busy                 = reset | (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_second           = sec_ff;
   assign rsp_minute           = min_ff;
   assign rsp_hour             = hour_ff;
   assign rsp_day_of_month     = days_ff[4:0] + 5'd1;
   assign rsp_month_index      = mon_ff;
   assign rsp_years_since_1900 = year_ff;
   assign rsp_weekday          = wday_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MONTH) |-> (mon_ff <= LAST_MONTH))
      else $error("month walk past December");

   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour <= 5'd23 && rsp_minute <= 6'd59 &&
                     rsp_second <= 6'd59 && rsp_weekday <= 3'd6))
      else $error("time field out of range");

endmodule
